[rtl/ial_pkg.sv]
`timescale 1ns / 1ps
// Package for the indexed array list: field widths, operation and status codes,
// sequencer state type and the control word handed to the storage cells.
// No dependencies.
package ial_pkg;

	localparam int FUNC_W = 2;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int MPOS_W = 5;
	localparam int CAP_W  = 6;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic               ins;    // insert at pos, shift later cells up
		logic               pop;    // remove at pos, shift later cells down
		logic               load;   // capture match flags for a search
		logic               shift;  // move match flags one cell toward the head
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   value;
	} cell_ctrl_t;

endpackage

[rtl/ial_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and response words.
// Depends on ial_pkg.
interface ial_cmd_if;
	import ial_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface

interface ial_rsp_if;
	import ial_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [VAL_W-1:0]  popped_value;
	logic                     found;
	logic [MPOS_W-1:0]        match_position;
	logic                     last;

	modport source (output valid, status, popped_value, found, match_position, last,
		input ready);
	modport sink   (input valid, status, popped_value, found, match_position, last,
		output ready);
endinterface

[rtl/ial_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list: holds one entry and one search match flag,
// trading data with its neighbors on insert, pop and flag shift.
// Depends on ial_pkg.
module ial_cell #(
	parameter int DEPTH = 32,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ial_pkg::cell_ctrl_t          ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]   cnt,
	input  logic [ial_pkg::VAL_W-1:0]    left_val,
	input  logic [ial_pkg::VAL_W-1:0]    right_val,
	input  logic                         right_flag,
	output logic [ial_pkg::VAL_W-1:0]    entry,
	output logic                         flag
);
	import ial_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] IDX_X = CMP_W'(IDX);

	logic [VAL_W-1:0] entry_q;
	logic             flag_q;
	logic [CMP_W-1:0] pos_x;
	logic             at_pos;
	logic             above;

	assign pos_x  = CMP_W'(ctrl.pos);
	assign at_pos = (pos_x == IDX_X);
	assign above  = (IDX_X > pos_x);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_pos) begin
				entry_q <= ctrl.value;
			end else if (above) begin
				entry_q <= left_val;
			end
		end else if (ctrl.pop) begin
			if (at_pos || above) begin
				entry_q <= right_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.load) begin
			// entries past the end never match
			flag_q <= (entry_q == ctrl.value) && (IDX_X < CMP_W'(cnt));
		end else if (ctrl.shift) begin
			flag_q <= right_flag;
		end
	end

	assign entry = entry_q;
	assign flag  = flag_q;

endmodule

[rtl/ial_seq.sv]
`timescale 1ns / 1ps
// Sequencer of the list: range and capacity checks, entry count, capacity
// register, search scan with one-behind pending match, response register.
// Depends on ial_pkg and ial_if.
module ial_seq #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ial_pkg::CAP_W-1:0]    cfg_wdata,
	ial_cmd_if.sink                      cmd,
	ial_rsp_if.source                    rsp,
	input  logic                         head_flag,
	input  logic [ial_pkg::VAL_W-1:0]    pop_data,
	output ial_pkg::cell_ctrl_t          ctrl,
	output logic [$clog2(DEPTH+1)-1:0]   cnt
);
	import ial_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CAP_W-1:0]   cap_q;
	logic               pend_q;
	logic [MPOS_W-1:0]  pend_pos_q;

	logic               rsp_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [VAL_W-1:0]   popped_q;
	logic               found_q;
	logic [MPOS_W-1:0]  mpos_q;
	logic               last_q;

	logic               out_free;
	logic               acc;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic               full;
	logic               scan_done;

	logic               emit;
	logic [STAT_W-1:0]  e_status;
	logic [VAL_W-1:0]   e_popped;
	logic               e_found;
	logic [MPOS_W-1:0]  e_mpos;
	logic               e_last;
	logic               ins_ok;
	logic               pop_ok;
	logic               load;
	logic               step;
	logic               pend_set;
	logic               pend_clr;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = out_free && (state_q == ST_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign pos_x     = CMP_W'(cmd.position);
	assign cnt_x     = CMP_W'(cnt_q);
	assign full      = (cnt_x >= CMP_W'(cap_q)) || (cnt_q == CNT_W'(DEPTH));
	assign scan_done = (scan_q == cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (cmd.func == FN_SEARCH)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (out_free && scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		e_status = STAT_OK;
		e_popped = '0;
		e_found  = 1'b0;
		e_mpos   = '0;
		e_last   = 1'b1;
		ins_ok   = 1'b0;
		pop_ok   = 1'b0;
		load     = 1'b0;
		step     = 1'b0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd.func)
						FN_INSERT: begin
							emit = 1'b1;
							if (pos_x > cnt_x) begin
								e_status = STAT_RANGE;
							end else if (full) begin
								e_status = STAT_FULL;
							end else begin
								ins_ok = 1'b1;
							end
						end
						FN_POP: begin
							emit = 1'b1;
							if (pos_x >= cnt_x) begin
								e_status = STAT_RANGE;
							end else begin
								pop_ok   = 1'b1;
								e_popped = pop_data;
							end
						end
						FN_SEARCH: begin
							load = 1'b1;
						end
						default: begin
							emit     = 1'b1;
							e_status = STAT_RANGE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (out_free) begin
					if (scan_done) begin
						// flush the held match as the final word, or report not found
						emit     = 1'b1;
						e_found  = pend_q;
						e_mpos   = pend_q ? pend_pos_q : '0;
						pend_clr = 1'b1;
					end else begin
						step = 1'b1;
						if (head_flag) begin
							pend_set = 1'b1;
							if (pend_q) begin
								emit    = 1'b1;
								e_found = 1'b1;
								e_mpos  = pend_pos_q;
								e_last  = 1'b0;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			cap_q       <= CAP_RESET;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ins_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load) begin
				scan_q <= '0;
			end else if (step) begin
				scan_q <= scan_q + 1'b1;
			end
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_set) begin
			pend_pos_q <= MPOS_W'(scan_q);
		end
		if (emit) begin
			status_q <= e_status;
			popped_q <= e_popped;
			found_q  <= e_found;
			mpos_q   <= e_mpos;
			last_q   <= e_last;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.popped_value   = popped_q;
	assign rsp.found          = found_q;
	assign rsp.match_position = mpos_q;
	assign rsp.last           = last_q;

	assign cnt        = cnt_q;
	assign ctrl.ins   = ins_ok;
	assign ctrl.pop   = pop_ok;
	assign ctrl.load  = load;
	assign ctrl.shift = step;
	assign ctrl.pos   = cmd.position;
	assign ctrl.value = cmd.value;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
		else $error("insert did not grow the list");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("response word overwritten");

	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SCAN))
		else $error("pending match outside a scan");

	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ((state_q == ST_SCAN) && (scan_q == '0)))
		else $error("search did not start a scan");

endmodule

[rtl/indexed_array_list.sv]
`timescale 1ns / 1ps
// Insert, pop and unknown words: the response word is registered at the accept edge,
// so one such word is taken per cycle while responses drain.
// Search: match flags load at the accept edge, then one cell position is scanned per
// cycle while the response side is free; a final word flushes the held match or reports
// not found, and no command is taken until the scan ends. Reset clears the count and
// sets capacity to 32; stored entries are not cleared and need no clearing pass.
module indexed_array_list #(
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ial_pkg::CAP_W-1:0]  cfg_wdata,
	ial_cmd_if.sink                    cmd,
	ial_rsp_if.source                  rsp
);
	import ial_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int IDX_W = $clog2(DEPTH);

	cell_ctrl_t          ctrl;
	logic [CNT_W-1:0]    cnt;
	logic [VAL_W-1:0]    entry [DEPTH];
	logic [DEPTH-1:0]    flag;
	logic [VAL_W-1:0]    pop_data;

	// pop reads only below the count, so the index is always in range
	assign pop_data = entry[IDX_W'(cmd.position)];

	ial_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.rsp       (rsp),
		.head_flag (flag[0]),
		.pop_data  (pop_data),
		.ctrl      (ctrl),
		.cnt       (cnt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_val;
		logic [VAL_W-1:0] right_val;
		logic             right_flag;

		if (i == 0) begin : g_head
			assign left_val = ctrl.value;
		end else begin : g_mid_l
			assign left_val = entry[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign right_val  = entry[i];
			assign right_flag = 1'b0;
		end else begin : g_mid_r
			assign right_val  = entry[i+1];
			assign right_flag = flag[i+1];
		end

		ial_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.cnt        (cnt),
			.left_val   (left_val),
			.right_val  (right_val),
			.right_flag (right_flag),
			.entry      (entry[i]),
			.flag       (flag[i])
		);
	end

endmodule

[verif/indexed_array_list_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for indexed_array_list: random and directed list commands
// checked word by word against a behavioral copy of the list kept in a class.
// Depends on ial_pkg, ial_if.sv and the indexed_array_list RTL.

typedef struct packed {
	logic [ial_pkg::STAT_W-1:0]        status;
	logic signed [ial_pkg::VAL_W-1:0]  popped_value;
	logic                              found;
	logic [ial_pkg::MPOS_W-1:0]        match_position;
	logic                              last;
} list_rsp_t;

class list_tracker;
	logic signed [ial_pkg::VAL_W-1:0] entries[$];
	logic [ial_pkg::CAP_W-1:0] capacity;
	list_rsp_t pending[$];
	int depth;
	int errors;

	function new(int depth_in);
		depth = depth_in;
		capacity = ial_pkg::CAP_RESET;
		errors = 0;
	endfunction

	function void write_capacity(logic [ial_pkg::CAP_W-1:0] cap);
		capacity = cap;
	endfunction

	function int length();
		return entries.size();
	endfunction

	function logic signed [ial_pkg::VAL_W-1:0] entry_at(int idx);
		return entries[idx];
	endfunction

	function int outstanding();
		return pending.size();
	endfunction

	function void queue_response(logic [ial_pkg::STAT_W-1:0] status,
			logic signed [ial_pkg::VAL_W-1:0] popped, logic found,
			logic [ial_pkg::MPOS_W-1:0] mpos, logic last);
		list_rsp_t r;
		r.status = status;
		r.popped_value = popped;
		r.found = found;
		r.match_position = mpos;
		r.last = last;
		pending.push_back(r);
	endfunction

	// Update the list for one accepted command word and queue its responses.
	function void apply_command(logic [ial_pkg::FUNC_W-1:0] fn,
			logic [ial_pkg::POS_W-1:0] pos, logic signed [ial_pkg::VAL_W-1:0] val);
		int limit;
		int hits;
		limit = (capacity < depth) ? capacity : depth;
		case (fn)
			ial_pkg::FN_INSERT: begin
				// range check comes before the full check
				if (pos > entries.size())
					queue_response(ial_pkg::STAT_RANGE, 0, 1'b0, 0, 1'b1);
				else if (entries.size() >= limit)
					queue_response(ial_pkg::STAT_FULL, 0, 1'b0, 0, 1'b1);
				else begin
					entries.insert(pos, val);
					queue_response(ial_pkg::STAT_OK, 0, 1'b0, 0, 1'b1);
				end
			end
			ial_pkg::FN_POP: begin
				if (entries.size() == 0 || pos >= entries.size())
					queue_response(ial_pkg::STAT_RANGE, 0, 1'b0, 0, 1'b1);
				else begin
					queue_response(ial_pkg::STAT_OK, entries[pos], 1'b0, 0, 1'b1);
					entries.delete(pos);
				end
			end
			ial_pkg::FN_SEARCH: begin
				hits = 0;
				foreach (entries[i]) begin
					if (entries[i] == val) begin
						queue_response(ial_pkg::STAT_OK, 0, 1'b1, i, 1'b0);
						hits++;
					end
				end
				if (hits == 0)
					queue_response(ial_pkg::STAT_OK, 0, 1'b0, 0, 1'b1);
				else
					pending[pending.size()-1].last = 1'b1;
			end
			default: begin
				queue_response(ial_pkg::STAT_RANGE, 0, 1'b0, 0, 1'b1);
			end
		endcase
	endfunction

	function void check_response(logic [ial_pkg::STAT_W-1:0] status,
			logic signed [ial_pkg::VAL_W-1:0] popped, logic found,
			logic [ial_pkg::MPOS_W-1:0] mpos, logic last);
		list_rsp_t want;
		if (pending.size() == 0) begin
			$error("response word with none pending: status %0d found %0d", status, found);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			errors++;
		end
		if (popped !== want.popped_value) begin
			$error("popped_value: expected %0d, got %0d", want.popped_value, popped);
			errors++;
		end
		if (found !== want.found) begin
			$error("found: expected %0d, got %0d", want.found, found);
			errors++;
		end
		if (mpos !== want.match_position) begin
			$error("match_position: expected %0d, got %0d", want.match_position, mpos);
			errors++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, last);
			errors++;
		end
	endfunction
endclass

module indexed_array_list_test;
	import ial_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [FUNC_W-1:0] FN_UNDEFINED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 45;
	localparam int CAP_PLAN [PHASES] = '{63, 4, 0, 20, 1, 32, 63};
	localparam int INSERT_PLAN [PHASES] = '{85, 20, 50, 60, 40, 30, 85};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic signed [VAL_W-1:0] common_values [7] = '{-2, -1, 0, 1, 2, VAL_MIN, VAL_MAX};

	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;
	list_tracker tracker;

	ial_cmd_if cmd_bus();
	ial_rsp_if rsp_bus();

	indexed_array_list #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check response words and watch for a stuck handshake.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			tracker.check_response(rsp_bus.status, rsp_bus.popped_value, rsp_bus.found,
				rsp_bus.match_position, rsp_bus.last);
		if (arst_n && ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response side: random stall before each word, one long hold on request.
	initial begin
		int stall;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else
				stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	// Offer one command word; valid stays high for a back-to-back follower.
	task automatic send_command(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= fn;
		cmd_bus.position <= pos;
		cmd_bus.value <= val;
		do @(posedge clk); while (!cmd_bus.ready);
		tracker.apply_command(fn, pos, val);
	endtask

	task automatic pause_until_drained();
		cmd_bus.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		// let a finishing scan clear before touching the register
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		pause_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.write_capacity(cap);
	endtask

	task automatic send_random(input int insert_pct);
		int n;
		int roll;
		logic [FUNC_W-1:0] fn;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		n = tracker.length();
		roll = $urandom_range(0, 99);
		if (roll < 3)
			fn = FN_UNDEFINED;
		else if (roll < 3 + insert_pct)
			fn = FN_INSERT;
		else if (roll < 3 + insert_pct + (97 - insert_pct) / 2)
			fn = FN_POP;
		else
			fn = FN_SEARCH;
		// mostly legal positions, now and then anything the field holds
		if ($urandom_range(0, 9) == 0)
			pos = $urandom_range(0, 63);
		else if (fn == FN_INSERT)
			pos = $urandom_range(0, n);
		else
			pos = (n == 0) ? 0 : $urandom_range(0, n - 1);
		// search mostly for stored values; a small pool makes duplicates
		if (fn == FN_SEARCH && n > 0 && $urandom_range(0, 3) != 0)
			val = tracker.entry_at($urandom_range(0, n - 1));
		else if ($urandom_range(0, 1) == 1)
			val = common_values[$urandom_range(0, 6)];
		else
			val = $urandom;
		send_command(fn, pos, val);
	endtask

	initial begin
		tracker = new(DEPTH);
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.func <= FN_INSERT;
		cmd_bus.position <= '0;
		cmd_bus.value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: pop and insert past the end refused, search finds nothing
		send_command(FN_POP, 0, 0);
		send_command(FN_SEARCH, 0, 0);
		send_command(FN_INSERT, 1, 5);
		send_command(FN_INSERT, 0, VAL_MIN);
		send_command(FN_INSERT, 1, VAL_MAX);
		send_command(FN_INSERT, 0, -1);
		send_command(FN_INSERT, 3, 0);
		send_command(FN_INSERT, 2, VAL_MAX);
		send_command(FN_SEARCH, 63, VAL_MAX);
		send_command(FN_SEARCH, 0, 12345);
		send_command(FN_POP, 5, 0);
		send_command(FN_POP, 63, 0);
		send_command(FN_INSERT, 63, 7);
		send_command(FN_UNDEFINED, 63, -1);
		send_command(FN_POP, 4, 0);
		send_command(FN_POP, 0, 0);
		send_command(FN_SEARCH, 0, VAL_MIN);
		// capacity below the current length: inserts full, pop and search still work
		set_capacity(2);
		send_command(FN_INSERT, 0, 9);
		send_command(FN_SEARCH, 0, VAL_MAX);
		send_command(FN_POP, 1, 0);
		set_capacity(0);
		send_command(FN_INSERT, 0, 1);
		send_command(FN_INSERT, 40, 1);

		for (int p = 0; p < PHASES; p++) begin
			set_capacity(CAP_PLAN[p]);
			quiet = (p == 3 || p == 5);
			// hold the response side long enough to back up the command side
			if (p == 5)
				hold_request = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k == PHASE_WORDS / 2)
					pause_until_drained();
				send_random(INSERT_PLAN[p]);
			end
		end

		cmd_bus.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/ial_pkg.sv
rtl/ial_if.sv
rtl/ial_cell.sv
rtl/ial_seq.sv
rtl/indexed_array_list.sv
verif/indexed_array_list_test.sv
